// ----- rtl/nsfa_pkg.sv -----
// ---------------------------------------------------------------------------
// nsfa_pkg - shared types and constants of the string and fret allocator
// item structs, mode codes, register codes, fixed point constants
// ---------------------------------------------------------------------------
package nsfa_pkg;

    localparam int STRINGS_DEF  = 6;
    localparam int MAX_FRET_DEF = 24;

    localparam logic [41:0] TUNING_RESET = 42'd2214977115816;
    localparam logic [5:0]  WOUND_RESET  = 6'd7;

    localparam logic [12:0] POS_RESET = 13'd512;
    localparam logic [12:0] POS_MIN   = 13'd256;
    localparam logic [12:0] POS_MAX   = 13'd4352;

    // datapath widths
    localparam int MUL_AW = 22;
    localparam int MUL_BW = 14;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int D2W    = 21;
    localparam int CW     = 40;

    typedef enum logic [1:0] {
        MODE_ASSIGN  = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_RESTORE = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    // register index taken from paddr bit 3
    localparam logic REG_TUNING = 1'b0;
    localparam logic REG_WOUND  = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  note;
        logic [3:0]  channel;
        logic [2:0]  preferred_string;
        logic [11:0] preferred_bonus;
        logic        allow_preferred_occupied;
    } req_t;

    typedef struct packed {
        logic       is_assignment;
        logic [2:0] string_index;
        logic [4:0] fret;
        logic       wound;
    } res_t;

    // open note of string i; strings past the table read as zero
    function automatic logic [6:0] tuning_note(input logic [41:0] tbl, input int unsigned i);
        logic [41:0] sh;
        sh = tbl >> (7 * i);
        return sh[6:0];
    endfunction

endpackage

// ----- rtl/note_to_string_fret_allocator.sv -----
// ---------------------------------------------------------------------------
// note_to_string_fret_allocator - picks string and fret for incoming notes
// scores each string that fits with one shared multiplier and a serial
// divider, keeps string occupancy and a smoothed hand position
// ---------------------------------------------------------------------------
//
//  channel   | signals                              | handshake
//  ----------+--------------------------------------+----------------------------
//  request   | start, busy, request                 | taken when start & !busy
//  result    | done, result                         | one cycle, strobe done
//  config    | psel penable pwrite paddr pwdata ... | write when psel&penable&pwrite
//
//  assign item: after acceptance the denominator step, then per fitting string the fit,
//  distance, register, scale, divide and compare steps (no divide if the register
//  range is degenerate), a fit step alone per non fitting string, then the hand steps
//  HAND1 and HAND2; the serial restoring divider (one quotient bit a cycle) dominates
//  release, restore and unknown modes answer in the cycle after acceptance
//  reset: tuning, wound mask, string state and hand position take reset values
//  at once; no clearing pass
//  the receiver cannot stall: each result shows for exactly one cycle
//
module note_to_string_fret_allocator
    import nsfa_pkg::*;
#(
    parameter int STRINGS  = STRINGS_DEF,
    parameter int MAX_FRET = MAX_FRET_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        done,
    output res_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int SW = $clog2(STRINGS);
    localparam logic [SW-1:0] LAST_IDX = SW'(STRINGS - 1);
    localparam logic [4:0]    FRET_MAX = 5'(MAX_FRET);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DEN, ST_FIT, ST_DIST, ST_NUM, ST_SCALE, ST_DIV, ST_CMP,
        ST_HAND1, ST_HAND2
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [41:0] tuning_reg;
    logic [5:0]  wound_reg;

    // string state
    logic [6:0]  open_reg    [STRINGS];
    logic        active_reg  [STRINGS];
    logic [6:0]  snote_reg   [STRINGS];
    logic [3:0]  schan_reg   [STRINGS];
    logic [12:0] pos_reg;

    // per item working registers
    req_t                req_reg;
    logic [SW-1:0]       idx_reg;
    logic [4:0]          f_reg;
    logic signed [13:0]  num_reg;
    logic [D2W-1:0]      d2_reg;
    logic                den_zero_reg;
    logic [21:0]         dsq_reg;
    logic [21:0]         n2_reg;
    logic [MUL_PW-1:0]   quo_reg;
    logic [D2W-1:0]      rem_reg;
    logic [5:0]          cnt_reg;
    logic                found_reg;
    logic signed [CW-1:0] best_cost_reg;
    logic [SW-1:0]       best_idx_reg;
    logic [4:0]          best_f_reg;
    logic [24:0]         acc_reg;
    logic                done_reg;
    res_t                result_reg;

    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_WOUND) ? {58'd0, wound_reg} : {22'd0, tuning_reg};

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // register mismatch terms, 14 bit wrap arithmetic (true values fit)
    logic signed [13:0] nl, hl, den, num;
    logic [12:0]        den_abs, num_abs;
    always_comb
    begin
        nl  = $signed({7'd0, req_reg.note}) - $signed({7'd0, open_reg[0]});
        hl  = $signed({7'd0, open_reg[STRINGS-1]}) + $signed(14'(MAX_FRET))
              - $signed({7'd0, open_reg[0]});
        den = 14'(hl * $signed(14'(STRINGS - 1)));
        num = 14'(nl * $signed(14'(STRINGS - 1)))
              - 14'($signed({{(14-SW){1'b0}}, idx_reg}) * hl);
        den_abs = den[13] ? 13'(-den) : den[12:0];
        num_abs = num_reg[13] ? 13'(-num_reg) : num_reg[12:0];
    end

    // fit check of the current string
    logic [7:0] fd;
    logic       fits;
    always_comb
    begin
        fd   = {1'b0, req_reg.note} - {1'b0, open_reg[idx_reg]};
        fits = !fd[7] && (fd[6:0] <= 7'(MAX_FRET));
    end

    // distance from hand position
    logic signed [13:0] hand_gap;
    logic [12:0]        hand_gap_abs;
    always_comb
    begin
        hand_gap     = $signed({1'b0, f_reg, 8'd0}) - $signed({1'b0, pos_reg});
        hand_gap_abs = hand_gap[13] ? 13'(-hand_gap) : hand_gap[12:0];
    end

    // hand move
    logic [12:0] target;
    logic        move_up;
    assign target  = {best_f_reg, 8'd0};
    assign move_up = target > pos_reg;

    // shared multiplier
    logic [MUL_AW-1:0] mul_a;
    logic [MUL_BW-1:0] mul_b;
    logic [MUL_PW-1:0] prod;
    always_comb
    begin
        case (state_reg)
            ST_DEN:
            begin
                mul_a = MUL_AW'(den_abs);
                mul_b = MUL_BW'(den_abs);
            end
            ST_DIST:
            begin
                mul_a = MUL_AW'(hand_gap_abs);
                mul_b = MUL_BW'(hand_gap_abs);
            end
            ST_NUM:
            begin
                mul_a = MUL_AW'(num_abs);
                mul_b = MUL_BW'(num_abs);
            end
            ST_SCALE:
            begin
                mul_a = n2_reg;
                mul_b = 14'd10240;
            end
            ST_HAND1:
            begin
                mul_a = MUL_AW'(pos_reg);
                mul_b = move_up ? 14'd2785 : 14'd3850;
            end
            ST_HAND2:
            begin
                mul_a = MUL_AW'(target);
                mul_b = move_up ? 14'd1311 : 14'd246;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = MUL_PW'(mul_a) * MUL_PW'(mul_b);
    end

    // divider step
    logic [D2W:0]   rem_sh;
    logic           ge;
    logic [D2W-1:0] rem_next;
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[MUL_PW-1]};
        ge       = rem_sh >= {1'b0, d2_reg};
        rem_next = ge ? D2W'(rem_sh - {1'b0, d2_reg}) : rem_sh[D2W-1:0];
    end

    // candidate cost
    logic signed [CW-1:0] cost;
    logic                 pref_hit;
    always_comb
    begin
        pref_hit = (req_reg.preferred_string == 3'(idx_reg));
        cost = $signed(CW'(dsq_reg)) + $signed(CW'(12'(f_reg) * 12'd123))
               + $signed(CW'(quo_reg));
        if (f_reg == 5'd0)
            cost = cost - CW'(492);
        if (f_reg >= 5'd1 && f_reg <= 5'd5)
            cost = cost - CW'(737);
        if (pref_hit)
            cost = cost - $signed(CW'({req_reg.preferred_bonus, 4'd0}));
        if (active_reg[idx_reg] && !(req_reg.allow_preferred_occupied && pref_hit))
            cost = cost + CW'(4096000);
    end

    // hand sum, round and clamp
    logic [25:0] hsum;
    logic [13:0] hnew;
    logic [12:0] hclamp;
    always_comb
    begin
        hsum = 26'(acc_reg) + 26'(prod[24:0]) + 26'd2048;
        hnew = hsum[25:12];
        if (hnew < 14'(POS_MIN))
            hclamp = POS_MIN;
        else if (hnew > 14'(POS_MAX))
            hclamp = POS_MAX;
        else
            hclamp = hnew[12:0];
    end

    logic [7:0] wound_ext;
    assign wound_ext = {2'b00, wound_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tuning_reg <= TUNING_RESET;
            wound_reg  <= WOUND_RESET;
            pos_reg    <= POS_RESET;
            done_reg   <= 1'b0;
            for (int i = 0; i < STRINGS; i++)
            begin
                open_reg[i]   <= tuning_note(TUNING_RESET, i);
                active_reg[i] <= 1'b0;
                snote_reg[i]  <= '0;
                schan_reg[i]  <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr)
            begin
                if (paddr[3] == REG_TUNING)
                    tuning_reg <= pwdata[41:0];
                else
                    wound_reg <= pwdata[5:0];
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        req_reg    <= request;
                        result_reg <= '0;
                        case (request.mode)
                            MODE_ASSIGN:
                            begin
                                if (request.note < open_reg[0])
                                    open_reg[0] <= request.note;
                                state_reg <= ST_DEN;
                            end
                            MODE_RELEASE:
                            begin
                                for (int i = 0; i < STRINGS; i++)
                                begin
                                    if (active_reg[i] && snote_reg[i] == request.note
                                        && schan_reg[i] == request.channel)
                                    begin
                                        active_reg[i] <= 1'b0;
                                        snote_reg[i]  <= '0;
                                        schan_reg[i]  <= '0;
                                    end
                                end
                                done_reg <= 1'b1;
                            end
                            MODE_RESTORE:
                            begin
                                for (int i = 0; i < STRINGS; i++)
                                begin
                                    open_reg[i]   <= tuning_note(tuning_reg, i);
                                    active_reg[i] <= 1'b0;
                                    snote_reg[i]  <= '0;
                                    schan_reg[i]  <= '0;
                                end
                                pos_reg  <= POS_RESET;
                                done_reg <= 1'b1;
                            end
                            default:
                                done_reg <= 1'b1;
                        endcase
                    end
                end
                ST_DEN:
                begin
                    d2_reg       <= prod[D2W-1:0];
                    den_zero_reg <= (den == 14'sd0);
                    found_reg    <= 1'b0;
                    best_idx_reg <= LAST_IDX;
                    best_f_reg   <= FRET_MAX;
                    idx_reg      <= '0;
                    state_reg    <= ST_FIT;
                end
                ST_FIT:
                begin
                    f_reg   <= fd[4:0];
                    num_reg <= num;
                    if (fits)
                        state_reg <= ST_DIST;
                    else if (idx_reg == LAST_IDX)
                        state_reg <= ST_HAND1;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_DIST:
                begin
                    dsq_reg   <= prod[25:4];
                    state_reg <= ST_NUM;
                end
                ST_NUM:
                begin
                    n2_reg    <= prod[21:0];
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    if (den_zero_reg)
                    begin
                        quo_reg   <= '0;
                        state_reg <= ST_CMP;
                    end
                    else
                    begin
                        quo_reg   <= prod;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[MUL_PW-2:0], ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'(MUL_PW - 1))
                        state_reg <= ST_CMP;
                end
                ST_CMP:
                begin
                    if (!found_reg || cost < best_cost_reg)
                    begin
                        found_reg     <= 1'b1;
                        best_cost_reg <= cost;
                        best_idx_reg  <= idx_reg;
                        best_f_reg    <= f_reg;
                    end
                    if (idx_reg == LAST_IDX)
                        state_reg <= ST_HAND1;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_FIT;
                    end
                end
                ST_HAND1:
                begin
                    acc_reg   <= prod[24:0];
                    state_reg <= ST_HAND2;
                end
                ST_HAND2:
                begin
                    pos_reg                    <= hclamp;
                    active_reg[best_idx_reg]   <= 1'b1;
                    snote_reg[best_idx_reg]    <= req_reg.note;
                    schan_reg[best_idx_reg]    <= req_reg.channel;
                    result_reg.is_assignment   <= 1'b1;
                    result_reg.string_index    <= 3'(best_idx_reg);
                    result_reg.fret            <= best_f_reg;
                    result_reg.wound           <= wound_ext[3'(best_idx_reg)];
                    done_reg                   <= 1'b1;
                    state_reg                  <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/nsfa_checker.sv -----
// ---------------------------------------------------------------------------
// nsfa_checker - port level checks of the string and fret allocator
// watches accepted items, result strobes and the apb ready line
// ---------------------------------------------------------------------------
module nsfa_checker
    import nsfa_pkg::*;
#(
    parameter int STRINGS = STRINGS_DEF
)(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input res_t result,
    input logic pready
);

    // an accepted item either answers next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted item neither answered nor in progress");

    // no result without an item behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without an item");

    // non assign results carry zero fields
    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.is_assignment) |->
        (result.string_index == 3'd0 && result.fret == 5'd0 && result.wound == 1'b0))
        else $error("acknowledgement with nonzero fields");

    // chosen string exists
    a_string_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_assignment) |-> (result.string_index < 3'(STRINGS)))
        else $error("string index out of range");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind note_to_string_fret_allocator nsfa_checker #(.STRINGS(STRINGS)) u_nsfa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result),
    .pready (pready)
);

// ----- tb/sv/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench - self-checking bench for the string and fret allocator
// directed table then random note streams, each result checked against the table or a
// cycle-free predictor of string choice, fret, wound flag and hand motion
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import nsfa_pkg::*;

    localparam int NSTR  = 6;
    localparam int MFRET = 24;
    localparam int RAND_ITEMS = 700;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        done;
    res_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    note_to_string_fret_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    // predictor copy of the block's registers and state
    logic [41:0] tuning_reg;
    logic [5:0]  wound_reg;
    logic [6:0]  open_note [NSTR];
    logic        occupied [NSTR];
    logic [6:0]  held_note [NSTR];
    logic [3:0]  held_chan [NSTR];
    logic [12:0] hand_pos;

    res_t   pending_results [$];
    int     fail_count;
    int     checked_count;
    int     assign_count;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic void restore_strings();
        for (int i = 0; i < NSTR; i++)
        begin
            open_note[i] = tuning_reg[7*i +: 7];
            occupied[i]  = 1'b0;
            held_note[i] = '0;
            held_chan[i] = '0;
        end
        hand_pos = POS_RESET;
    endfunction

    // fixed point cost of placing the note on string s at fret f
    function automatic longint string_cost(int s, longint f, req_t rq);
        longint dpos;
        longint c;
        longint lo;
        longint hi;
        longint num;
        longint den;
        dpos = f * 256 - longint'(hand_pos);
        c  = (dpos * dpos) >>> 4;
        c += f * 123;
        lo = open_note[0];
        hi = longint'(open_note[NSTR-1]) + MFRET;
        num = (longint'(rq.note) - lo) * (NSTR - 1) - s * (hi - lo);
        den = (hi - lo) * (NSTR - 1);
        if (den != 0)
            c += (num * num * 10240) / (den * den);
        if (f == 0)
            c -= 492;
        if (f >= 1 && f <= 5)
            c -= 737;
        if (s == rq.preferred_string && rq.preferred_bonus != 0)
            c -= longint'(rq.preferred_bonus) * 16;
        if (occupied[s] && !(rq.allow_preferred_occupied && s == rq.preferred_string))
            c += 1000 * 4096;
        return c;
    endfunction

    function automatic res_t allocate_note(req_t rq);
        res_t   r;
        bit     found;
        int     best_s;
        longint best_f;
        longint best_c;
        longint f;
        longint c;
        longint p;
        longint tgt;
        r = '0;
        found = 0;
        best_s = NSTR - 1;
        best_f = MFRET;
        best_c = 0;
        case (mode_t'(rq.mode))
            MODE_ASSIGN:
            begin
                if (rq.note < open_note[0])
                    open_note[0] = rq.note;
                for (int i = 0; i < NSTR; i++)
                begin
                    f = longint'(rq.note) - longint'(open_note[i]);
                    if (f >= 0 && f <= MFRET)
                    begin
                        c = string_cost(i, f, rq);
                        if (!found || c < best_c)
                        begin
                            found = 1;
                            best_c = c;
                            best_s = i;
                            best_f = f;
                        end
                    end
                end
                occupied[best_s]  = 1'b1;
                held_note[best_s] = rq.note;
                held_chan[best_s] = rq.channel;
                // asymmetric smoothing toward the chosen fret
                p = hand_pos;
                tgt = best_f * 256;
                if (tgt > p)
                    p = (2785 * p + 1311 * tgt + 2048) >>> 12;
                else
                    p = (3850 * p + 246 * tgt + 2048) >>> 12;
                if (p < POS_MIN)
                    p = POS_MIN;
                else if (p > POS_MAX)
                    p = POS_MAX;
                hand_pos = p[12:0];
                r.is_assignment = 1'b1;
                r.string_index  = best_s[2:0];
                r.fret          = best_f[4:0];
                r.wound         = wound_reg[best_s];
            end
            MODE_RELEASE:
                for (int i = 0; i < NSTR; i++)
                    if (occupied[i] && held_note[i] == rq.note && held_chan[i] == rq.channel)
                    begin
                        occupied[i]  = 1'b0;
                        held_note[i] = '0;
                        held_chan[i] = '0;
                    end
            MODE_RESTORE:
                restore_strings();
            default:
                ;
        endcase
        return r;
    endfunction

    // result checker: the receiver never stalls, every strobe is an item
    always @(posedge clk)
    begin
        res_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no expectation: %p", result);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                checked_count++;
                if (result.is_assignment !== exp_r.is_assignment)
                begin
                    $error("is_assignment exp %0d got %0d", exp_r.is_assignment,
                           result.is_assignment);
                    fail_count++;
                end
                if (result.string_index !== exp_r.string_index)
                begin
                    $error("string_index exp %0d got %0d", exp_r.string_index,
                           result.string_index);
                    fail_count++;
                end
                if (result.fret !== exp_r.fret)
                begin
                    $error("fret exp %0d got %0d", exp_r.fret, result.fret);
                    fail_count++;
                end
                if (result.wound !== exp_r.wound)
                begin
                    $error("wound exp %0d got %0d", exp_r.wound, result.wound);
                    fail_count++;
                end
            end
        end
    end

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    // mostly short gaps, sometimes long, often none
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    task automatic write_reg(logic [3:0] addr, logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[3] == REG_TUNING)
            tuning_reg = data[41:0];
        else
            wound_reg = data[5:0];
    endtask

    // wait for all expectations, then let an unanswered pipeline drain
    task automatic drain_block();
        while (pending_results.size() != 0)
            @(posedge clk);
        idle_cycles(300);
    endtask

    // hand one item to the block; start stays high across back-to-back items
    task automatic send_item(req_t rq, bit hold_start);
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(allocate_note(rq));
        if (rq.mode == MODE_ASSIGN)
            assign_count++;
        if (!hold_start)
            start <= 1'b0;
    endtask

    task automatic send_paced(req_t rq);
        int g;
        g = gap_length();
        send_item(rq, g == 0);
        idle_cycles(g);
    endtask

    function automatic req_t make_req(mode_t m, int nt, int ch, int ps, int bn, bit ao);
        req_t rq;
        rq.mode = m;
        rq.note = 7'(nt);
        rq.channel = 4'(ch);
        rq.preferred_string = 3'(ps);
        rq.preferred_bonus = 12'(bn);
        rq.allow_preferred_occupied = ao;
        return rq;
    endfunction

    function automatic req_t random_req();
        req_t rq;
        int r;
        rq = 29'($urandom);
        r = $urandom_range(0, 99);
        // mostly playable notes with channel reuse so releases hit
        if (r < 65)
        begin
            rq.mode = MODE_ASSIGN;
            if ($urandom_range(0, 9) < 8)
                rq.note = 7'($urandom_range(30, 90));
            rq.channel = 4'($urandom_range(0, 3));
        end
        else if (r < 88)
        begin
            rq.mode = MODE_RELEASE;
            rq.note = 7'($urandom_range(30, 90));
            rq.channel = 4'($urandom_range(0, 3));
        end
        else if (r < 95)
            rq.mode = MODE_RESTORE;
        else
            rq.mode = MODE_NONE;
        if ($urandom_range(0, 3) == 0)
            rq.preferred_bonus = '0;
        return rq;
    endfunction

    // directed rows; expectation only where it is obvious, else predicted
    typedef struct {
        req_t rq;
        bit   typed;
        res_t want;
    } dir_row_t;

    dir_row_t dir_rows [$];

    task automatic add_row(req_t rq, bit typed, res_t want);
        dir_row_t row;
        row.rq = rq;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    task automatic build_table();
        // acknowledgements of non-assign items are all zero
        add_row(make_req(MODE_RELEASE, 0, 0, 0, 0, 0), 1, '0);
        add_row(make_req(MODE_NONE, 127, 15, 7, 4095, 1), 1, '0);
        // low E on open string 0, wound
        add_row(make_req(MODE_ASSIGN, 40, 0, 7, 0, 0), 1, '{1'b1, 3'd0, 5'd0, 1'b1});
        add_row(make_req(MODE_RESTORE, 0, 0, 0, 0, 0), 1, '0);
        // top of range: nothing fits, last string at max fret
        add_row(make_req(MODE_ASSIGN, 127, 15, 6, 0, 0), 1, '{1'b1, 3'd5, 5'd24, 1'b0});
        add_row(make_req(MODE_ASSIGN, 0, 1, 0, 4095, 0), 0, '0);   // retune string 0 down
        add_row(make_req(MODE_ASSIGN, 0, 2, 0, 4095, 1), 0, '0);   // preferred occupied waived
        add_row(make_req(MODE_ASSIGN, 64, 3, 5, 4095, 1), 0, '0);
        add_row(make_req(MODE_ASSIGN, 64, 4, 2, 2048, 0), 0, '0);
        add_row(make_req(MODE_ASSIGN, 64, 5, 3, 1, 0), 0, '0);
        add_row(make_req(MODE_RELEASE, 64, 3, 0, 0, 0), 0, '0);
        add_row(make_req(MODE_ASSIGN, 88, 15, 4, 100, 0), 0, '0);
        add_row(make_req(MODE_ASSIGN, 50, 9, 1, 0, 1), 0, '0);
        add_row(make_req(MODE_RELEASE, 127, 15, 0, 0, 0), 0, '0);
        add_row(make_req(MODE_ASSIGN, 45, 10, 6, 0, 0), 0, '0);
        add_row(make_req(MODE_ASSIGN, 45, 11, 7, 0, 0), 0, '0);
        add_row(make_req(MODE_ASSIGN, 45, 12, 0, 0, 0), 0, '0);
        add_row(make_req(MODE_RESTORE, 0, 0, 0, 0, 0), 0, '0);
    endtask

    // start is dropped at the end so an idle block takes no stale item
    task automatic run_random(int n);
        for (int k = 0; k < n; k++)
            send_paced(random_req());
        start <= 1'b0;
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        fail_count = 0;
        checked_count = 0;
        assign_count = 0;
        tuning_reg = TUNING_RESET;
        wound_reg  = WOUND_RESET;
        restore_strings();
        build_table();
        idle_cycles(12);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, back to back
        foreach (dir_rows[k])
        begin
            send_item(dir_rows[k].rq, k < dir_rows.size() - 1);
            if (dir_rows[k].typed)
                pending_results[pending_results.size()-1] = dir_rows[k].want;
        end
        drain_block();

        // registers: extremes and a random setting; a restore item loads tuning
        write_reg(4'h8, 64'h3F);
        write_reg(4'h0, 64'h3FF_FFFF_FFFF);
        send_item(make_req(MODE_RESTORE, 0, 0, 0, 0, 0), 1);
        run_random(RAND_ITEMS / 7);
        drain_block();

        write_reg(4'h8, 64'h0);
        write_reg(4'h0, 64'h0);      // all strings at note zero, hi minus lo is max fret
        send_item(make_req(MODE_RESTORE, 0, 0, 0, 0, 0), 1);
        run_random(RAND_ITEMS / 7);
        drain_block();

        // all strings on one note: hi minus lo is max fret again
        write_reg(4'h0, {22'd0, {6{7'd40}}});
        write_reg(4'h8, 64'h2A);
        send_item(make_req(MODE_RESTORE, 0, 0, 0, 0, 0), 1);
        run_random(RAND_ITEMS / 7);
        drain_block();

        write_reg(4'h8, {58'd0, 6'($urandom)});
        write_reg(4'h0, {22'd0, 7'd64, 7'd59, 7'd55, 7'd50, 7'd45, 7'd40});
        send_item(make_req(MODE_RESTORE, 0, 0, 0, 0, 0), 1);
        run_random(RAND_ITEMS / 7);
        drain_block();

        write_reg(4'h0, {22'd0, TUNING_RESET});
        write_reg(4'h8, {58'd0, WOUND_RESET});
        send_item(make_req(MODE_RESTORE, 0, 0, 0, 0, 0), 1);
        run_random(RAND_ITEMS * 3 / 7);

        drain_block();
        $display("covered %0d results (%0d assigns) over five tuning and wound settings",
                 checked_count, assign_count);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // 723 items plus long gaps, taken several times over
    initial
    begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
